[hw/rtl/cset_pkg.sv]
// Shared types and constants for the cache set replacement block.
package cset_pkg;

    localparam int TAG_W  = 32;
    localparam int TIME_W = 32;
    localparam int CFG_W  = 4;
    localparam int CFG_IDX_W = 2;

    typedef enum logic [1:0] {
        MODE_LOOKUP = 2'd0,
        MODE_INSERT = 2'd1,
        MODE_TOUCH  = 2'd2,
        MODE_DIRTY  = 2'd3
    } mode_t;

    localparam logic [CFG_IDX_W-1:0] REG_REPLACE_FIFO  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WRITE_THROUGH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WAYS_IN_USE   = 2'd2;

    localparam logic [CFG_W-1:0] WAYS_IN_USE_RESET = 4'd8;

    typedef struct packed {
        logic [1:0]        mode;
        logic [TAG_W-1:0]  tag;
        logic [TIME_W-1:0] now;
    } cset_in_t;

    typedef struct packed {
        logic             hit;
        logic             evicted;
        logic [TAG_W-1:0] victim_tag;
        logic             writeback;
    } cset_out_t;

    // Victim candidate handed from cell to cell
    typedef struct packed {
        logic              found;
        logic [TIME_W-1:0] key;
        logic [TAG_W-1:0]  tag;
    } cand_t;

    // Update command to one cell
    typedef struct packed {
        logic load;
        logic kill;
        logic touch;
        logic mark;
    } cell_ctl_t;

    // Status reported by one cell
    typedef struct packed {
        logic valid;
        logic dirty;
        logic hit;
        logic vhit;
    } cell_stat_t;

endpackage

[hw/rtl/cache_set_fifo_lru_replace.sv]
// Cache set with FIFO or LRU replacement: a row of way cells and the sequencing control.
// IDLE takes the input transaction and LOOK registers the result; an insert that evicts
//   first runs SCAN and then COMMIT, as the victim candidate walks the row one cell a cycle.
// A new transaction is taken only in IDLE, after the last one has been committed.
// Reset clears all valid and dirty bits, the occupancy count and the registers
//   (FIFO off, write-back, eight ways in use); tags and time stamps are left as they are.
module cache_set_fifo_lru_replace
    import cset_pkg::*;
#(
    parameter int WAYS = 8
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  cset_in_t             in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output cset_out_t            out_data,
    input  logic                 cfg_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    localparam int CNT_W = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int OCC_W = $clog2(WAYS + 1);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_LOOK   = 4'b0010,
        S_SCAN   = 4'b0100,
        S_COMMIT = 4'b1000
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [OCC_W-1:0] occ_reg, occ_next;
    cset_in_t         item_reg;
    logic             replace_fifo_reg;
    logic             write_through_reg;
    logic [CFG_W-1:0] ways_in_use_reg;
    logic             out_valid_reg, out_valid_next;
    cset_out_t        out_reg, out_next;

    cell_ctl_t        ctl  [WAYS];
    cell_stat_t       stat [WAYS];
    cand_t            cand [WAYS+1];

    logic [WAYS-1:0]  hit_vec, vhit_vec, valid_vec, dirty_vec, free_vec, sel_vec;
    logic             hit, evict, out_free, need_scan, do_commit, is_insert;
    logic [7:0]       cap, occ_wide;

    assign cand[0] = '0;

    for (genvar k = 0; k < WAYS; k++)
    begin : g_cell
        cset_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .fifo       (replace_fifo_reg),
            .item_tag   (item_reg.tag),
            .now        (item_reg.now),
            .victim_tag (cand[WAYS].tag),
            .ctl        (ctl[k]),
            .cand_in    (cand[k]),
            .cand_out   (cand[k+1]),
            .stat       (stat[k])
        );
    end

    always_comb
    begin
        for (int k = 0; k < WAYS; k++)
        begin
            hit_vec[k]   = stat[k].hit;
            vhit_vec[k]  = stat[k].vhit;
            valid_vec[k] = stat[k].valid;
            dirty_vec[k] = stat[k].dirty;
        end
    end

    // Clamp capacity to the range one to WAYS
    always_comb
    begin
        if (ways_in_use_reg == '0)
            cap = 8'd1;
        else if ({4'b0000, ways_in_use_reg} > 8'(WAYS))
            cap = 8'(WAYS);
        else
            cap = {4'b0000, ways_in_use_reg};
    end

    assign occ_wide  = 8'(occ_reg);
    assign hit       = |hit_vec;
    assign is_insert = (item_reg.mode == MODE_INSERT);
    assign need_scan = is_insert && !hit && (occ_wide >= cap);
    assign out_free  = !out_valid_reg || out_ready;
    assign evict     = (state_reg == S_COMMIT) && cand[WAYS].found;
    assign do_commit = out_free && (((state_reg == S_LOOK) && !need_scan) ||
                                    (state_reg == S_COMMIT));

    // Lowest free way after the victim has been dropped
    assign free_vec = ~valid_vec | (evict ? vhit_vec : '0);
    assign sel_vec  = free_vec & (~free_vec + WAYS'(1));

    always_comb
    begin
        for (int k = 0; k < WAYS; k++)
        begin
            ctl[k].load  = do_commit && is_insert && (hit ? hit_vec[k] : sel_vec[k]);
            ctl[k].kill  = do_commit && is_insert && !hit && evict && vhit_vec[k];
            ctl[k].touch = do_commit && (item_reg.mode == MODE_TOUCH) && hit_vec[k];
            ctl[k].mark  = do_commit && (item_reg.mode == MODE_DIRTY) && hit_vec[k];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                    state_next = S_LOOK;
            end
            S_LOOK:
            begin
                if (need_scan)
                    state_next = S_SCAN;
                else if (do_commit)
                    state_next = S_IDLE;
            end
            S_SCAN:
            begin
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(WAYS - 1))
                begin
                    cnt_next   = '0;
                    state_next = S_COMMIT;
                end
            end
            S_COMMIT:
            begin
                if (do_commit)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        occ_next = occ_reg;
        if (do_commit && is_insert && !hit && !evict)
            occ_next = occ_reg + OCC_W'(1);
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (out_ready)
            out_valid_next = 1'b0;
        if (do_commit)
        begin
            out_valid_next      = 1'b1;
            out_next.hit        = hit;
            out_next.evicted    = evict;
            out_next.victim_tag = evict ? cand[WAYS].tag : '0;
            out_next.writeback  = evict && !write_through_reg && |(vhit_vec & dirty_vec);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            cnt_reg           <= '0;
            occ_reg           <= '0;
            out_valid_reg     <= 1'b0;
            replace_fifo_reg  <= 1'b0;
            write_through_reg <= 1'b0;
            ways_in_use_reg   <= WAYS_IN_USE_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            occ_reg       <= occ_next;
            out_valid_reg <= out_valid_next;
            if (cfg_en)
            begin
                case (cfg_index)
                    REG_REPLACE_FIFO:  replace_fifo_reg  <= cfg_data[0];
                    REG_WRITE_THROUGH: write_through_reg <= cfg_data[0];
                    REG_WAYS_IN_USE:   ways_in_use_reg   <= cfg_data;
                    default:           ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
        if (in_valid && in_ready)
            item_reg <= in_data;
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

`ifndef NO_ASSERTIONS
    a_occ_matches_valid: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(valid_vec) == int'(occ_reg))
        else $error("occupancy count disagrees with valid entries");

    a_tag_unique: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(hit_vec))
        else $error("tag present in more than one way");

    a_victim_found: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_COMMIT) |-> (cand[WAYS].found && $onehot(vhit_vec)))
        else $error("victim search ended without a unique victim");

    a_writeback_needs_evict: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.writeback) |-> out_data.evicted)
        else $error("write-back flagged without eviction");
`endif

endmodule

[hw/rtl/cset_cell.sv]
// One way of the set: entry storage, tag compare and one step of the victim search.
module cset_cell
    import cset_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              fifo,
    input  logic [TAG_W-1:0]  item_tag,
    input  logic [TIME_W-1:0] now,
    input  logic [TAG_W-1:0]  victim_tag,
    input  cell_ctl_t         ctl,
    input  cand_t             cand_in,
    output cand_t             cand_out,
    output cell_stat_t        stat
);

    logic              valid_reg;
    logic              dirty_reg;
    logic [TAG_W-1:0]  tag_reg;
    logic [TIME_W-1:0] load_reg;
    logic [TIME_W-1:0] access_reg;
    cand_t             cand_reg;
    cand_t             cand_next;
    logic [TIME_W-1:0] own_key;
    logic              better;

    assign own_key = fifo ? load_reg : access_reg;

    // A valid entry takes over if none found yet, or older, or as old with a smaller tag
    always_comb
    begin
        better = valid_reg && (!cand_in.found || (own_key < cand_in.key) ||
                 ((own_key == cand_in.key) && (tag_reg < cand_in.tag)));
        cand_next = cand_in;
        if (better)
        begin
            cand_next.found = 1'b1;
            cand_next.key   = own_key;
            cand_next.tag   = tag_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            dirty_reg <= 1'b0;
            cand_reg  <= '0;
        end
        else
        begin
            cand_reg <= cand_next;
            if (ctl.load)
            begin
                valid_reg <= 1'b1;
                dirty_reg <= 1'b0;
            end
            else if (ctl.kill)
            begin
                valid_reg <= 1'b0;
                dirty_reg <= 1'b0;
            end
            else if (ctl.mark)
            begin
                dirty_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            tag_reg    <= item_tag;
            load_reg   <= now;
            access_reg <= now;
        end
        else if (ctl.touch)
        begin
            access_reg <= now;
        end
    end

    assign cand_out   = cand_reg;
    assign stat.valid = valid_reg;
    assign stat.dirty = dirty_reg;
    assign stat.hit   = valid_reg && (tag_reg == item_tag);
    assign stat.vhit  = valid_reg && (tag_reg == victim_tag);

endmodule
